@@ sv/indexed_stack_with_insert_macros.svh @@
// ----------------------------------------------------------------------------
// indexed_stack_with_insert_macros.svh
// Assertion macros shared by the indexed stack RTL.
// ----------------------------------------------------------------------------
`ifndef INDEXED_STACK_WITH_INSERT_MACROS_SVH
`define INDEXED_STACK_WITH_INSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ISI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ISI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/isi_pkg.sv @@
// ----------------------------------------------------------------------------
// isi_pkg
// Types and constants of the indexed stack with insert.
// ----------------------------------------------------------------------------
package isi_pkg;

    localparam int DATA_W        = 32;
    localparam int DEFAULT_DEPTH = 1024;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_READ   = 2'd2,
        OP_INSERT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_STORE
    } state_t;

endpackage

@@ sv/isi_ram.sv @@
// ----------------------------------------------------------------------------
// isi_ram
// Word store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module isi_ram #(
    parameter int DEPTH = isi_pkg::DEFAULT_DEPTH,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = isi_pkg::DATA_W
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/indexed_stack_with_insert.sv @@
// ----------------------------------------------------------------------------
// indexed_stack_with_insert
// Fixed-capacity stack of signed words with push, pop, indexed read and
// indexed insert, built around one single-port-write memory.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; every request gives
// exactly one result beat, shown for one cycle with done high, and the
// receiver cannot hold it off. For a push, an insert at the top (i == n)
// and any request that fails (full, empty, index out of range) busy stays
// low, so the next request may follow at once. A pop or a read passes
// through S_READ, as the memory read port registers its data. For an insert
// at index i below n stored words, the later words move up one place a
// cycle through the memory's single write port, led by one shared address
// decrement and compare, and then the new word is written. The memory has
// no reset and needs no clearing pass; only data read from filled places is
// ever used. fill_count reports the count after the request.
// ----------------------------------------------------------------------------
`include "indexed_stack_with_insert_macros.svh"

module indexed_stack_with_insert #(
    parameter int DEPTH = isi_pkg::DEFAULT_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        op,
    input  logic signed [isi_pkg::DATA_W-1:0] value,
    input  logic [$clog2(DEPTH + 1)-1:0]      index,
    output logic                              done,
    output logic signed [isi_pkg::DATA_W-1:0] result_word,
    output logic [1:0]                        status,
    output logic [$clog2(DEPTH + 1)-1:0]      fill_count
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IW    = CW;
    localparam int OUT_W = CW;
    localparam int DW    = isi_pkg::DATA_W;
    localparam int CMPW  = (CW > IW) ? CW : IW;

    // Sequencer state and datapath registers.
    isi_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [AW-1:0]   ptr_reg, ptr_next;     // destination of the current move
    logic [AW-1:0]   idx_reg, idx_next;     // insert position
    logic [DW-1:0]   val_reg, val_next;     // word waiting to be inserted
    logic            done_reg, done_next;
    logic [DW-1:0]   word_reg, word_next;
    isi_pkg::status_t status_reg, status_next;

    // Memory port.
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;

    // Request decode.
    isi_pkg::op_t  req_op;
    logic          accept;
    logic          is_full;
    logic          is_empty;
    logic          rd_oob;
    logic          ins_oob;
    logic          ins_at_end;
    logic          last_move;
    logic [AW-1:0] ptr_dec;

    assign req_op     = isi_pkg::op_t'(op);
    assign accept     = start && (state_reg == isi_pkg::S_IDLE);
    assign is_full    = (fill_reg == CW'(DEPTH));
    assign is_empty   = (fill_reg == '0);
    assign rd_oob     = (CMPW'(index) >= CMPW'(fill_reg));
    assign ins_oob    = (CMPW'(index) >  CMPW'(fill_reg));
    assign ins_at_end = (CMPW'(index) == CMPW'(fill_reg));

    // Shared decrement / compare that steps the insert move downward.
    assign ptr_dec    = ptr_reg - AW'(1);
    assign last_move  = (ptr_dec == idx_reg);

    isi_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            isi_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (req_op)
                        isi_pkg::OP_PUSH:
                        begin
                            state_next = isi_pkg::S_IDLE;
                        end
                        isi_pkg::OP_POP:
                        begin
                            state_next = is_empty ? isi_pkg::S_IDLE : isi_pkg::S_READ;
                        end
                        isi_pkg::OP_READ:
                        begin
                            state_next = rd_oob ? isi_pkg::S_IDLE : isi_pkg::S_READ;
                        end
                        isi_pkg::OP_INSERT:
                        begin
                            if (is_full || ins_oob || ins_at_end)
                            begin
                                state_next = isi_pkg::S_IDLE;
                            end
                            else
                            begin
                                state_next = isi_pkg::S_SHIFT;
                            end
                        end
                    endcase
                end
            end
            isi_pkg::S_READ:
            begin
                state_next = isi_pkg::S_IDLE;
            end
            isi_pkg::S_SHIFT:
            begin
                state_next = last_move ? isi_pkg::S_STORE : isi_pkg::S_SHIFT;
            end
            isi_pkg::S_STORE:
            begin
                state_next = isi_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and result control.
    always_comb
    begin
        mem_we      = 1'b0;
        mem_waddr   = ptr_reg;
        mem_wdata   = mem_rdata;
        mem_raddr   = ptr_dec;
        fill_next   = fill_reg;
        ptr_next    = ptr_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        done_next   = 1'b0;
        word_next   = '0;
        status_next = isi_pkg::STAT_OK;
        unique case (state_reg)
            isi_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_op)
                        isi_pkg::OP_PUSH:
                        begin
                            done_next = 1'b1;
                            if (is_full)
                            begin
                                status_next = isi_pkg::STAT_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(fill_reg);
                                mem_wdata = value;
                                fill_next = fill_reg + CW'(1);
                            end
                        end
                        isi_pkg::OP_POP:
                        begin
                            if (is_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = isi_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                fill_next = fill_reg - CW'(1);
                                mem_raddr = AW'(fill_reg - CW'(1));
                            end
                        end
                        isi_pkg::OP_READ:
                        begin
                            if (rd_oob)
                            begin
                                done_next   = 1'b1;
                                status_next = isi_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                mem_raddr = AW'(index);
                            end
                        end
                        isi_pkg::OP_INSERT:
                        begin
                            priority if (is_full)
                            begin
                                done_next   = 1'b1;
                                status_next = isi_pkg::STAT_FULL;
                            end
                            else if (ins_oob)
                            begin
                                done_next   = 1'b1;
                                status_next = isi_pkg::STAT_RANGE;
                            end
                            else if (ins_at_end)
                            begin
                                done_next = 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = AW'(fill_reg);
                                mem_wdata = value;
                                fill_next = fill_reg + CW'(1);
                            end
                            else
                            begin
                                // Fetch the top word; it moves up first.
                                ptr_next  = AW'(fill_reg);
                                idx_next  = AW'(index);
                                val_next  = value;
                                mem_raddr = AW'(fill_reg - CW'(1));
                            end
                        end
                    endcase
                end
            end
            isi_pkg::S_READ:
            begin
                done_next = 1'b1;
                word_next = mem_rdata;
            end
            isi_pkg::S_SHIFT:
            begin
                // Write the word fetched last cycle one place up, fetch the next.
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = mem_rdata;
                mem_raddr = ptr_reg - AW'(2);
                ptr_next  = ptr_dec;
            end
            isi_pkg::S_STORE:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = val_reg;
                fill_next = fill_reg + CW'(1);
                done_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= isi_pkg::S_IDLE;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        word_reg   <= word_next;
        status_reg <= status_next;
    end

    assign busy        = (state_reg != isi_pkg::S_IDLE);
    assign done        = done_reg;
    assign result_word = word_reg;
    assign status      = status_reg;
    assign fill_count  = OUT_W'(fill_reg);

    // A push always answers in the following cycle.
    `ISI_ASSERT_NEXT(a_push_one_cycle, start && !busy && (op == isi_pkg::OP_PUSH), done, "push late")
    // A full report only when the store really is full.
    `ISI_ASSERT_NOW(a_full_status, done && (status == isi_pkg::STAT_FULL), is_full, "full with room")
    // The move pointer stays above the insert position.
    `ISI_ASSERT_NOW(a_shift_bound, state_reg == isi_pkg::S_SHIFT, ptr_reg > idx_reg, "move past index")
    // No result beat while words are still moving.
    `ISI_ASSERT_NOW(a_quiet_shift, state_reg == isi_pkg::S_SHIFT, !done, "result during insert move")

endmodule
